// File: rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free list allocator
// Field widths, default sizing, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package fla_pkg;

	localparam int REGION_BYTES_DEF    = 65536;
	localparam int MAX_FREE_BLOCKS_DEF = 16;
	localparam int HEADER_BYTES_DEF    = 16;
	localparam int NODE_BYTES_DEF      = 16;
	localparam int MAX_ALIGN_DEF       = 4096;

	localparam int KIND_W    = 2;
	localparam int SIZE_W    = 17;
	localparam int ALIGN_W   = 13;
	localparam int ADDRESS_W = 16;
	localparam int STATUS_W  = 2;
	localparam int TOTAL_W   = 17;
	localparam int MIN_ALIGN = 8;

	// header word: padding before the header above, span length below
	localparam int HB_LEN_W = 17;
	localparam int HB_PAD_W = 13;
	localparam int HB_W     = HB_LEN_W + HB_PAD_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_RESET = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_BAD  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_A_RD,
		S_A_LOAD,
		S_A_DIV,
		S_A_PAD,
		S_A_CMP,
		S_A_COMMIT,
		S_F_HDR,
		S_F_RD,
		S_F_CHK,
		S_F_EVAL,
		S_DN_RD,
		S_DN_WR,
		S_UP_RD,
		S_UP_WR,
		S_UP_FIN,
		S_DONE
	} state_t;

endpackage

// File: rtl/free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// free_list_allocator_unit: region allocator over a sorted free extent table
// Allocate (first or best fit, aligned, with header), free with coalescing,
// region reset; used and peak byte counts.
// ----------------------------------------------------------------------------
// Steps: allocate reads each extent, takes the start offset's remainder by the
//   alignment bit serially, raises the padding past the header and compares;
//   free reads the header, checks each extent, then merges or inserts; both
//   shift entries. A bad-header free, reset region and other rejects skip these.
// Throughput: one request at a time; the next beat is taken the cycle after the
//   result is loaded into the output register; a stalled result holds the block.
// Reset: arst_n clears control state; the first cycle after reset writes the
//   single whole region extent into table entry 0. Header store is not cleared.
// ----------------------------------------------------------------------------
module free_list_allocator_unit #(
	parameter int REGION_BYTES    = fla_pkg::REGION_BYTES_DEF,
	parameter int MAX_FREE_BLOCKS = fla_pkg::MAX_FREE_BLOCKS_DEF,
	parameter int HEADER_BYTES    = fla_pkg::HEADER_BYTES_DEF,
	parameter int NODE_BYTES      = fla_pkg::NODE_BYTES_DEF,
	parameter int MAX_ALIGN       = fla_pkg::MAX_ALIGN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// policy register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fla_pkg::KIND_W-1:0]    kind,
	input  logic [fla_pkg::SIZE_W-1:0]    request_size,
	input  logic [fla_pkg::ALIGN_W-1:0]   alignment,
	input  logic [fla_pkg::ADDRESS_W-1:0] address,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fla_pkg::STATUS_W-1:0]  status,
	output logic [fla_pkg::ADDRESS_W-1:0] data_address,
	output logic [fla_pkg::TOTAL_W-1:0]   used_total,
	output logic [fla_pkg::TOTAL_W-1:0]   peak_total
);
	import fla_pkg::*;

	// offsets, lengths, wide scratch width for sums and compares
	localparam int ADDR_W   = $clog2(REGION_BYTES);
	localparam int LEN_W    = ADDR_W + 1;
	localparam int WW       = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 2;
	localparam int FL_W     = ADDR_W + LEN_W;
	localparam int FB_AW    = $clog2(MAX_FREE_BLOCKS);
	localparam int CNT_W    = $clog2(MAX_FREE_BLOCKS + 1);
	localparam int HDR_DEPTH = REGION_BYTES / 8;
	localparam int HDR_AW   = $clog2(HDR_DEPTH);
	localparam int BIT_W    = $clog2(ADDR_W);
	localparam int PAD_W    = ALIGN_W + 1;

	state_t state_q, state_d;

	// free extent table: {start, length}, one read and one write port
	logic [FL_W-1:0]  fl_mem [MAX_FREE_BLOCKS];
	logic [FL_W-1:0]  fl_rd_q;
	logic [FB_AW-1:0] fl_ra, fl_wa;
	logic [FL_W-1:0]  fl_wd;
	logic             fl_we;

	// header store, indexed by data address / 8
	logic [HB_W-1:0]   hdr_mem [HDR_DEPTH];
	logic [HB_W-1:0]   hdr_rd_q;
	logic [HDR_AW-1:0] hdr_ra, hdr_wa;
	logic [HB_W-1:0]   hdr_wd;
	logic              hdr_we;

	// architectural state
	logic             policy_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] used_q, peak_q;

	// request registers
	logic [SIZE_W-1:0]    size_q;
	logic [ALIGN_W-1:0]   align_q;
	logic [ADDRESS_W-1:0] addr_q;

	// scan state
	logic [CNT_W-1:0]   i_q;
	logic [ADDR_W-1:0]  ent_start_q;
	logic [LEN_W-1:0]   ent_len_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [BIT_W-1:0]   bit_q;
	logic [PAD_W-1:0]   pad_q;
	logic               found_q;
	logic [CNT_W-1:0]   best_q;
	logic [PAD_W-1:0]   best_pad_q;
	logic [LEN_W-1:0]   best_slack_q;
	logic [ADDR_W-1:0]  best_start_q;

	// free path state
	logic [ADDR_W-1:0]   s_q;
	logic [HB_LEN_W-1:0] blk_q;
	logic                prev_valid_q;
	logic [ADDR_W-1:0]   prev_start_q;
	logic [LEN_W-1:0]    prev_len_q;
	logic [WW-1:0]       prev_end_q;
	logic                pos_found_q;
	logic [CNT_W-1:0]    pos_q;
	logic [ADDR_W-1:0]   next_start_q;
	logic [LEN_W-1:0]    next_len_q;

	// result
	status_t              res_status_q;
	logic [ADDR_W-1:0]    res_data_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [ADDRESS_W-1:0] out_data_q;
	logic [TOTAL_W-1:0]   out_used_q, out_peak_q;

	// ---------------- datapath terms ----------------
	logic               accept;
	logic               alloc_bad;
	logic               idx_ok;
	logic [ADDR_W-1:0]  rd_start;
	logic [LEN_W-1:0]   rd_len;
	logic [ALIGN_W:0]   rem_sh;
	logic [ALIGN_W-1:0] rem_nx;
	logic [WW-1:0]      req_w, slack_w;
	logic               fits, better, last_ent;
	logic [WW-1:0]      breq_w;
	logic [ADDR_W-1:0]  d_c;
	logic               split;
	logic [HB_LEN_W-1:0] h_blk;
	logic [HB_PAD_W-1:0] h_pad;
	logic [WW-1:0]      s_wide;
	logic               free_bad;
	logic [WW-1:0]      e_end, s_end;
	logic               overlap;
	logic               prev_adj, next_adj;
	logic [CNT_W-1:0]   pos_m1;
	logic               out_free;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign alloc_bad = (request_size < SIZE_W'(NODE_BYTES)) ||
		(alignment < ALIGN_W'(MIN_ALIGN)) || (32'(alignment) > MAX_ALIGN);
	assign idx_ok    = (32'(address) >> 3) < HDR_DEPTH;

	assign rd_start = fl_rd_q[FL_W-1:LEN_W];
	assign rd_len   = fl_rd_q[LEN_W-1:0];

	// one remainder bit per cycle, start offset MSB first
	assign rem_sh = {rem_q, ent_start_q[bit_q]};
	assign rem_nx = (rem_sh >= {1'b0, align_q}) ? ALIGN_W'(rem_sh - {1'b0, align_q})
		: rem_sh[ALIGN_W-1:0];

	assign req_w    = WW'(size_q) + WW'(pad_q);
	assign fits     = WW'(ent_len_q) >= req_w;
	assign slack_w  = WW'(ent_len_q) - req_w;
	assign better   = fits && (!found_q || (LEN_W'(slack_w) < best_slack_q));
	assign last_ent = (i_q + CNT_W'(1)) == count_q;

	assign breq_w = WW'(size_q) + WW'(best_pad_q);
	assign d_c    = ADDR_W'(WW'(best_start_q) + WW'(best_pad_q));
	assign split  = WW'(best_slack_q) >= (WW'(NODE_BYTES) + WW'(align_q));

	assign h_blk    = hdr_rd_q[HB_LEN_W-1:0];
	assign h_pad    = hdr_rd_q[HB_W-1:HB_LEN_W];
	assign s_wide   = WW'(addr_q) - WW'(HEADER_BYTES) - WW'(h_pad);
	assign free_bad = (h_blk == '0) ||
		(WW'(addr_q) < (WW'(HEADER_BYTES) + WW'(h_pad))) ||
		((s_wide + WW'(h_blk)) > WW'(REGION_BYTES)) ||
		(WW'(h_blk) > WW'(used_q));

	assign e_end   = WW'(rd_start) + WW'(rd_len);
	assign s_end   = WW'(s_q) + WW'(blk_q);
	assign overlap = (WW'(s_q) < e_end) && (WW'(rd_start) < s_end);

	assign prev_adj = prev_valid_q && (prev_end_q == WW'(s_q));
	assign next_adj = pos_found_q && (s_end == WW'(next_start_q));
	assign pos_m1   = pos_q - CNT_W'(1);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		fl_ra   = i_q[FB_AW-1:0];
		fl_we   = 1'b0;
		fl_wa   = i_q[FB_AW-1:0];
		fl_wd   = fl_rd_q;
		hdr_ra  = HDR_AW'(address >> 3);
		hdr_we  = 1'b0;
		hdr_wa  = HDR_AW'(d_c >> 3);
		hdr_wd  = {HB_PAD_W'(best_pad_q - PAD_W'(HEADER_BYTES)), HB_LEN_W'(breq_w)};
		case (state_q)
			S_INIT: begin
				fl_we   = 1'b1;
				fl_wa   = '0;
				fl_wd   = {ADDR_W'(0), LEN_W'(REGION_BYTES)};
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (kind_t'(kind))
						KIND_ALLOC: state_d = (alloc_bad || count_q == '0) ? S_DONE : S_A_RD;
						KIND_FREE:  state_d = idx_ok ? S_F_HDR : S_DONE;
						KIND_RESET: begin
							fl_we   = 1'b1;
							fl_wa   = '0;
							fl_wd   = {ADDR_W'(0), LEN_W'(REGION_BYTES)};
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_A_RD:   state_d = S_A_LOAD;
			S_A_LOAD: state_d = S_A_DIV;
			S_A_DIV:  if (bit_q == '0) state_d = S_A_PAD;
			S_A_PAD:  if (pad_q >= PAD_W'(HEADER_BYTES)) state_d = S_A_CMP;
			S_A_CMP: begin
				if ((fits && !policy_q) || last_ent) begin
					state_d = S_A_COMMIT;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_COMMIT: begin
				if (!found_q) begin
					state_d = S_DONE;
				end else begin
					hdr_we = 1'b1;
					if (split) begin
						fl_we   = 1'b1;
						fl_wa   = best_q[FB_AW-1:0];
						fl_wd   = {ADDR_W'(WW'(best_start_q) + breq_w), best_slack_q};
						state_d = S_DONE;
					end else if ((best_q + CNT_W'(1)) < count_q) begin
						state_d = S_DN_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_F_HDR: begin
				if (free_bad) begin
					state_d = S_DONE;
				end else if (count_q == '0) begin
					state_d = S_F_EVAL;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_RD: state_d = S_F_CHK;
			S_F_CHK: begin
				if (overlap) begin
					state_d = S_DONE;
				end else if (last_ent) begin
					state_d = S_F_EVAL;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_EVAL: begin
				hdr_wa = HDR_AW'(addr_q >> 3);
				hdr_wd = '0;
				if (prev_adj) begin
					hdr_we = 1'b1;
					fl_we  = 1'b1;
					fl_wa  = pos_m1[FB_AW-1:0];
					if (next_adj) begin
						fl_wd = {prev_start_q,
							LEN_W'(WW'(prev_len_q) + WW'(blk_q) + WW'(next_len_q))};
						state_d = ((pos_q + CNT_W'(1)) < count_q) ? S_DN_RD : S_DONE;
					end else begin
						fl_wd   = {prev_start_q, LEN_W'(WW'(prev_len_q) + WW'(blk_q))};
						state_d = S_DONE;
					end
				end else if (next_adj) begin
					hdr_we  = 1'b1;
					fl_we   = 1'b1;
					fl_wa   = pos_q[FB_AW-1:0];
					fl_wd   = {s_q, LEN_W'(WW'(next_len_q) + WW'(blk_q))};
					state_d = S_DONE;
				end else if (count_q >= CNT_W'(MAX_FREE_BLOCKS)) begin
					state_d = S_DONE;
				end else begin
					hdr_we  = 1'b1;
					state_d = (count_q > pos_q) ? S_UP_RD : S_UP_FIN;
				end
			end
			// remove entry i: move i+1 down to i until the end of the table
			S_DN_RD: begin
				fl_ra   = FB_AW'(i_q + CNT_W'(1));
				state_d = S_DN_WR;
			end
			S_DN_WR: begin
				fl_we   = 1'b1;
				state_d = ((i_q + CNT_W'(2)) < count_q) ? S_DN_RD : S_DONE;
			end
			// open slot at pos: move i-1 up to i, from the end downward
			S_UP_RD: begin
				fl_ra   = FB_AW'(i_q - CNT_W'(1));
				state_d = S_UP_WR;
			end
			S_UP_WR: begin
				fl_we   = 1'b1;
				state_d = ((i_q - CNT_W'(1)) > pos_q) ? S_UP_RD : S_UP_FIN;
			end
			S_UP_FIN: begin
				fl_we   = 1'b1;
				fl_wa   = pos_q[FB_AW-1:0];
				fl_wd   = {s_q, LEN_W'(blk_q)};
				state_d = S_DONE;
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_wa] <= fl_wd;
		end
		fl_rd_q <= fl_mem[fl_ra];
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_wa] <= hdr_wd;
		end
		hdr_rd_q <= hdr_mem[hdr_ra];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= 1'b0;
			count_q     <= CNT_W'(1);
			used_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			// result beat: load on completion, drop once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && kind_t'(kind) == KIND_RESET) begin
						count_q <= CNT_W'(1);
						used_q  <= '0;
						peak_q  <= '0;
					end
				end
				S_A_COMMIT: begin
					if (found_q) begin
						used_q <= LEN_W'(WW'(used_q) + breq_w);
						if (LEN_W'(WW'(used_q) + breq_w) > peak_q) begin
							peak_q <= LEN_W'(WW'(used_q) + breq_w);
						end
						if (!split && (best_q + CNT_W'(1)) >= count_q) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				S_F_EVAL: begin
					if (prev_adj || next_adj || count_q < CNT_W'(MAX_FREE_BLOCKS)) begin
						used_q <= used_q - LEN_W'(blk_q);
					end
					if (prev_adj && next_adj && (pos_q + CNT_W'(1)) >= count_q) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_DN_WR: begin
					if ((i_q + CNT_W'(2)) >= count_q) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_UP_FIN: count_q <= count_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				size_q     <= request_size;
				align_q    <= alignment;
				addr_q     <= address;
				i_q        <= '0;
				found_q    <= 1'b0;
				res_data_q <= '0;
				case (kind_t'(kind))
					KIND_ALLOC: res_status_q <= alloc_bad ? ST_BAD : ST_OOM;
					KIND_FREE:  res_status_q <= ST_BAD;
					KIND_RESET: res_status_q <= ST_OK;
					default:    res_status_q <= ST_BAD;
				endcase
			end
			S_A_LOAD: begin
				ent_start_q <= rd_start;
				ent_len_q   <= rd_len;
				rem_q       <= '0;
				bit_q       <= BIT_W'(ADDR_W - 1);
			end
			S_A_DIV: begin
				rem_q <= rem_nx;
				bit_q <= bit_q - BIT_W'(1);
				if (bit_q == '0) begin
					pad_q <= PAD_W'(align_q) - PAD_W'(rem_nx);
				end
			end
			S_A_PAD: begin
				if (pad_q < PAD_W'(HEADER_BYTES)) begin
					pad_q <= pad_q + PAD_W'(align_q);
				end
			end
			S_A_CMP: begin
				if (better) begin
					found_q      <= 1'b1;
					best_q       <= i_q;
					best_pad_q   <= pad_q;
					best_slack_q <= LEN_W'(slack_w);
					best_start_q <= ent_start_q;
				end
				i_q <= i_q + CNT_W'(1);
			end
			S_A_COMMIT: begin
				if (found_q) begin
					res_status_q <= ST_OK;
					res_data_q   <= d_c;
					i_q          <= best_q;
				end
			end
			S_F_HDR: begin
				blk_q        <= h_blk;
				s_q          <= ADDR_W'(s_wide);
				prev_valid_q <= 1'b0;
				pos_found_q  <= 1'b0;
				pos_q        <= count_q;
			end
			S_F_CHK: begin
				if (rd_start < s_q) begin
					prev_valid_q <= 1'b1;
					prev_start_q <= rd_start;
					prev_len_q   <= rd_len;
					prev_end_q   <= e_end;
				end else if (!pos_found_q) begin
					pos_found_q  <= 1'b1;
					pos_q        <= i_q;
					next_start_q <= rd_start;
					next_len_q   <= rd_len;
				end
				i_q <= i_q + CNT_W'(1);
			end
			S_F_EVAL: begin
				if (prev_adj || next_adj) begin
					res_status_q <= ST_OK;
				end else if (count_q >= CNT_W'(MAX_FREE_BLOCKS)) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= ST_OK;
				end
				i_q <= (prev_adj && next_adj) ? pos_q : count_q;
			end
			S_DN_WR: i_q <= i_q + CNT_W'(1);
			S_UP_WR: i_q <= i_q - CNT_W'(1);
			S_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_data_q   <= (res_status_q == ST_OK) ? ADDRESS_W'(res_data_q) : '0;
					out_used_q   <= TOTAL_W'(used_q);
					out_peak_q   <= TOTAL_W'(peak_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign data_address = out_data_q;
	assign used_total   = out_used_q;
	assign peak_total   = out_peak_q;

	// ---------------- checks ----------------
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FREE_BLOCKS))
		else $error("free extent count above table depth");

	a_peak_ge_used: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q)
		else $error("peak below used byte count");

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(used_q) <= WW'(REGION_BYTES))
		else $error("used bytes exceed region");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat raised outside completion");

endmodule

// File: test/tb_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_free_list_allocator_unit: self-checking bench of the region allocator
// Drives allocate, free and reset-region requests with random idles and
// stalls, predicts every result from an internal model of the free extent
// table and compares it field by field. Policy is switched between phases.
// ----------------------------------------------------------------------------
module tb_free_list_allocator_unit;
	import fla_pkg::*;

	localparam int REGION   = 65536;
	localparam int MAX_EXT  = 16;
	localparam int HDR      = 16;
	localparam int NODE     = 16;
	localparam int ALIGN_HI = 4096;
	localparam int WDOG     = 200000;

	typedef struct packed {
		kind_t                  kind;
		logic [SIZE_W-1:0]      size;
		logic [ALIGN_W-1:0]     align;
		logic [ADDRESS_W-1:0]   addr;
	} req_t;

	typedef struct packed {
		status_t                st;
		logic [ADDRESS_W-1:0]   data;
		logic [TOTAL_W-1:0]     used;
		logic [TOTAL_W-1:0]     peak;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [SIZE_W-1:0] request_size = '0;
	logic [ALIGN_W-1:0] alignment = '0;
	logic [ADDRESS_W-1:0] address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ADDRESS_W-1:0] data_address;
	logic [TOTAL_W-1:0] used_total;
	logic [TOTAL_W-1:0] peak_total;

	free_list_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.request_size(request_size), .alignment(alignment), .address(address),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.data_address(data_address), .used_total(used_total),
		.peak_total(peak_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---- predictor state: sorted free extents, header words, counters ----
	int unsigned ext_start [MAX_EXT];
	int unsigned ext_len [MAX_EXT];
	int unsigned ext_cnt;
	int unsigned used_b, peak_b;
	int unsigned hdr_word [REGION/8];
	bit hdr_seen [REGION/8];      // header entry written at least once
	bit fit_best;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;              // no idles or stalls while set
	bit took_in = 0;

	function automatic int unsigned header_pad(int unsigned base, int unsigned a);
		int unsigned p;
		p = a - (base % a);
		if (p < HDR)
			p += a * ((HDR - p + a - 1) / a);
		return p;
	endfunction

	function automatic void drop_extent(int unsigned k);
		for (int unsigned i = k; i + 1 < ext_cnt; i++) begin
			ext_start[i] = ext_start[i+1];
			ext_len[i] = ext_len[i+1];
		end
		ext_cnt--;
		ext_start[ext_cnt] = 0;
		ext_len[ext_cnt] = 0;
	endfunction

	function automatic void restore_region();
		foreach (ext_start[i]) begin
			ext_start[i] = 0;
			ext_len[i] = 0;
		end
		ext_len[0] = REGION;
		ext_cnt = 1;
		used_b = 0;
		peak_b = 0;
	endfunction

	function automatic status_t predict_alloc(int unsigned sz, int unsigned a,
			output int unsigned d);
		int unsigned best, bpad, bslack, p, need, st;
		bit found;
		found = 0; best = 0; bpad = 0; bslack = 0; d = 0;
		if (sz < NODE || a < MIN_ALIGN || a > ALIGN_HI)
			return ST_BAD;
		for (int unsigned i = 0; i < ext_cnt; i++) begin
			p = header_pad(ext_start[i], a);
			need = sz + p;
			if (ext_len[i] >= need) begin
				if (!found || ext_len[i] - need < bslack) begin
					found = 1; best = i; bpad = p; bslack = ext_len[i] - need;
				end
				if (!fit_best)
					break;
			end
		end
		if (!found)
			return ST_OOM;
		st = ext_start[best];
		need = sz + bpad;
		d = st + bpad;
		if (bslack >= NODE + a) begin
			ext_start[best] = st + need;
			ext_len[best] = bslack;
		end else begin
			drop_extent(best);
		end
		if ((d >> 3) < REGION / 8) begin
			hdr_word[d >> 3] = (need & 32'h1FFFF) | (((bpad - HDR) & 32'h1FFF) << 17);
			hdr_seen[d >> 3] = 1'b1;
		end
		used_b += need;
		if (used_b > peak_b)
			peak_b = used_b;
		return ST_OK;
	endfunction

	function automatic status_t predict_free(int unsigned a);
		int unsigned h, blk, pad, s, pos;
		bit pa, na;
		h = hdr_word[a >> 3];
		blk = h & 32'h1FFFF;
		pad = (h >> 17) & 32'h1FFF;
		if (blk == 0 || a < HDR + pad)
			return ST_BAD;
		s = a - HDR - pad;
		if (s + blk > REGION || blk > used_b)
			return ST_BAD;
		for (int unsigned i = 0; i < ext_cnt; i++)
			if (s < ext_start[i] + ext_len[i] && ext_start[i] < s + blk)
				return ST_BAD;
		pos = 0;
		while (pos < ext_cnt && ext_start[pos] < s)
			pos++;
		pa = pos > 0 && ext_start[pos-1] + ext_len[pos-1] == s;
		na = pos < ext_cnt && s + blk == ext_start[pos];
		if (pa && na) begin
			ext_len[pos-1] += blk + ext_len[pos];
			drop_extent(pos);
		end else if (pa) begin
			ext_len[pos-1] += blk;
		end else if (na) begin
			ext_start[pos] = s;
			ext_len[pos] += blk;
		end else begin
			if (ext_cnt >= MAX_EXT)
				return ST_FULL;
			for (int unsigned i = ext_cnt; i > pos; i--) begin
				ext_start[i] = ext_start[i-1];
				ext_len[i] = ext_len[i-1];
			end
			ext_start[pos] = s;
			ext_len[pos] = blk;
			ext_cnt++;
		end
		hdr_word[a >> 3] = 0;
		used_b -= blk;
		return ST_OK;
	endfunction

	// Works out the result of one request and updates the model.
	function automatic rsp_t predict_result(req_t r);
		rsp_t o;
		int unsigned d;
		d = 0;
		case (r.kind)
			KIND_ALLOC: o.st = predict_alloc(r.size, r.align, d);
			KIND_FREE:  o.st = predict_free(r.addr);
			KIND_RESET: begin
				restore_region();
				o.st = ST_OK;
			end
			default:    o.st = ST_BAD;
		endcase
		o.data = (o.st == ST_OK) ? d[ADDRESS_W-1:0] : '0;
		o.used = used_b[TOTAL_W-1:0];
		o.peak = peak_b[TOTAL_W-1:0];
		return o;
	endfunction

	// ---- driver: present the head of the pending queue ----
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || took_in) begin
				if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
					in_valid <= 1'b1;
					kind <= pending_reqs[0].kind;
					request_size <= pending_reqs[0].size;
					alignment <= pending_reqs[0].align;
					address <= pending_reqs[0].addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 6);
		end
	end

	// ---- monitor: accept beats on the rising edge ----
	always @(posedge clk) begin
		rsp_t e;
		bit hit;
		hit = 0;
		took_in = 0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(predict_result(pending_reqs.pop_front()));
				took_in = 1;
				hit = 1;
			end
			if (out_valid && !out_stall) begin
				hit = 1;
				if (expected_rsps.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status);
						errors++;
					end
					if (data_address !== e.data) begin
						$error("data_address exp %0d got %0d", e.data, data_address);
						errors++;
					end
					if (used_total !== e.used) begin
						$error("used_total exp %0d got %0d", e.used, used_total);
						errors++;
					end
					if (peak_total !== e.peak) begin
						$error("peak_total exp %0d got %0d", e.peak, peak_total);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				hit = 1;
			quiet_cycles = hit ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Queue one request beat.
	task automatic push_req(kind_t k, int unsigned sz, int unsigned a, int unsigned ad);
		req_t r;
		r.kind = k;
		r.size = sz[SIZE_W-1:0];
		r.align = a[ALIGN_W-1:0];
		r.addr = ad[ADDRESS_W-1:0];
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_policy(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		fit_best = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Free addresses are chosen when a beat is queued, so they target data
	// offsets the model has handed out, or offsets near a header entry that
	// was written at some point. Never-written header entries are not read.
	function automatic bit pick_free_addr(output int unsigned ad);
		int unsigned live [$];
		int unsigned seen [$];
		ad = 0;
		for (int unsigned i = 0; i < REGION / 8; i++) begin
			if (hdr_seen[i]) begin
				seen.push_back(i);
				if (hdr_word[i] != 0)
					live.push_back(i * 8);
			end
		end
		if (seen.size() == 0)
			return 1'b0;
		if (live.size() == 0 || $urandom_range(9) == 0)
			ad = seen[$urandom_range(seen.size() - 1)] * 8 + $urandom_range(7);
		else
			ad = live[$urandom_range(live.size() - 1)];
		return 1'b1;
	endfunction

	task automatic random_phase(int n);
		int unsigned sel, sz, a, k, ad;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 50) begin
				sz = ($urandom_range(9) == 0) ? $urandom_range(131071)
					: $urandom_range(16, 3000);
				k = $urandom_range(3, 12);
				a = ($urandom_range(19) == 0) ? $urandom_range(8191) : (1 << k);
				push_req(KIND_ALLOC, sz, a, $urandom);
			end else if (sel < 92) begin
				if (pick_free_addr(ad))
					push_req(KIND_FREE, $urandom, $urandom_range(8191), ad);
				else
					push_req(KIND_NONE, $urandom, $urandom, $urandom);
			end else if (sel < 96) begin
				push_req(KIND_RESET, $urandom, $urandom, $urandom);
			end else begin
				push_req(KIND_NONE, $urandom, $urandom, $urandom);
			end
			// keep the queue short so free targets track recent allocations
			while (pending_reqs.size() > 2)
				@(posedge clk);
		end
	endtask

	initial begin
		foreach (hdr_word[i])
			hdr_word[i] = 0;
		restore_region();
		fit_best = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: field extremes, every kind, bad requests
		calm = 1'b1;
		push_req(KIND_ALLOC, 15, 8, 0);
		push_req(KIND_ALLOC, 16, 7, 0);
		push_req(KIND_ALLOC, 16, 4097, 0);
		push_req(KIND_ALLOC, 16, 8191, 65535);
		push_req(KIND_ALLOC, 131071, 8, 0);
		push_req(KIND_ALLOC, 65536, 8, 0);
		push_req(KIND_ALLOC, 16, 8, 0);
		push_req(KIND_ALLOC, 100, 4096, 0);
		push_req(KIND_ALLOC, 40, 16, 0);
		push_req(KIND_FREE, 0, 0, 16);
		push_req(KIND_FREE, 0, 0, 16);
		push_req(KIND_FREE, 0, 0, 23);
		push_req(KIND_FREE, 0, 0, 4096);
		push_req(KIND_NONE, 131071, 8191, 65535);
		push_req(KIND_RESET, 0, 0, 0);
		push_req(KIND_FREE, 0, 0, 4096);
		push_req(KIND_ALLOC, 65520, 8, 0);
		push_req(KIND_ALLOC, 16, 8, 0);
		push_req(KIND_RESET, 0, 0, 0);
		drain();
		calm = 1'b0;

		write_policy(1'b1);
		random_phase(300);
		drain();
		write_policy(1'b0);
		calm = 1'b1;
		random_phase(150);
		calm = 1'b0;
		random_phase(200);
		drain();
		write_policy(1'b1);
		random_phase(280);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
